// ===== hw/rtl/idle_cstate_promotion_policy_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the idle C-state promotion policy
// Implication checks clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef IDLE_CSTATE_PROMOTION_POLICY_ASSERT_SVH
`define IDLE_CSTATE_PROMOTION_POLICY_ASSERT_SVH

// Same-cycle implication
`define ICPP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("icpp assertion failed");

// Next-cycle implication
`define ICPP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("icpp assertion failed");

`endif

// ===== hw/rtl/icpp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icpp_pkg
// Shared types, codes and helpers of the idle C-state promotion policy.
// ----------------------------------------------------------------------------
package icpp_pkg;

  localparam int unsigned NUM_STATES = 4;
  localparam int unsigned CNT_W      = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Processor sleep states
  typedef enum logic [1:0] {
    CST_C0 = 2'd0,
    CST_C1 = 2'd1,
    CST_C2 = 2'd2,
    CST_C3 = 2'd3
  } cstate_e;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BUSY_LIMIT      = 3'd0,
    CFG_DEEPEST_STATE   = 3'd1,
    CFG_PROMOTE_TIME_C1 = 3'd2,
    CFG_PROMOTE_TIME_C2 = 3'd3,
    CFG_DEMOTE_TIME_C2  = 3'd4,
    CFG_DEMOTE_TIME_C3  = 3'd5,
    CFG_COUNT_LIMIT     = 3'd6,
    CFG_BUS_MASTER_MASK = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [31:0]      busy_limit;
    logic [1:0]       deepest_state;
    logic [15:0]      promote_time_c1;
    logic [15:0]      promote_time_c2;
    logic [15:0]      demote_time_c2;
    logic [15:0]      demote_time_c3;
    logic [CNT_W-1:0] count_limit;
    logic [31:0]      bus_master_mask;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    busy_limit:      32'd2,
    deepest_state:   2'd2,
    promote_time_c1: 16'd0,
    promote_time_c2: 16'd0,
    demote_time_c2:  16'd0,
    demote_time_c3:  16'd0,
    count_limit:     8'd1,
    bus_master_mask: 32'h0000_000F
  };

  typedef struct packed {
    cstate_e sleep_state;
    cstate_e next_cstate;
    logic    bus_master_reload;
  } res_t;

  // Saturating counter increment
  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    sat_inc = (c == CNT_MAX) ? CNT_MAX : c + CNT_W'(1);
  endfunction

endpackage

// ===== hw/rtl/icpp_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icpp_cfg_regs
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module icpp_cfg_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [icpp_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [icpp_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output icpp_pkg::cfg_t                    cfg_o
);

  icpp_pkg::cfg_t cfg_q, cfg_d;

  // Decode the write
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (icpp_pkg::cfg_idx_e'(cfg_idx_i))
        icpp_pkg::CFG_BUSY_LIMIT:      cfg_d.busy_limit      = cfg_data_i;
        icpp_pkg::CFG_DEEPEST_STATE:   cfg_d.deepest_state   = cfg_data_i[1:0];
        icpp_pkg::CFG_PROMOTE_TIME_C1: cfg_d.promote_time_c1 = cfg_data_i[15:0];
        icpp_pkg::CFG_PROMOTE_TIME_C2: cfg_d.promote_time_c2 = cfg_data_i[15:0];
        icpp_pkg::CFG_DEMOTE_TIME_C2:  cfg_d.demote_time_c2  = cfg_data_i[15:0];
        icpp_pkg::CFG_DEMOTE_TIME_C3:  cfg_d.demote_time_c3  = cfg_data_i[15:0];
        icpp_pkg::CFG_COUNT_LIMIT:     cfg_d.count_limit     = cfg_data_i[icpp_pkg::CNT_W-1:0];
        icpp_pkg::CFG_BUS_MASTER_MASK: cfg_d.bus_master_mask = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= icpp_pkg::CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hw/rtl/icpp_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icpp_step
// Policy state and the combinational promotion / demotion decision.
// ----------------------------------------------------------------------------
module icpp_step #(
  parameter int unsigned HISTORY_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  icpp_pkg::cfg_t        cfg_i,
  input  logic                  fire_i,
  input  logic [31:0]           tick_i,
  input  logic                  bm_i,
  input  logic [31:0]           sleep_i,
  output icpp_pkg::res_t        res_o
);

  localparam int unsigned MASK_W = (HISTORY_BITS < 32) ? HISTORY_BITS : 32;
  localparam int unsigned CW     = icpp_pkg::CNT_W;
  localparam int unsigned NS     = icpp_pkg::NUM_STATES;

  icpp_pkg::cstate_e       state_q, state_d;
  logic [HISTORY_BITS-1:0] hist_q, hist_d;
  logic [31:0]             last_q, last_d;
  logic [CW-1:0]           pcnt_q [NS];
  logic [CW-1:0]           pcnt_d [NS];
  logic [CW-1:0]           dcnt_q [NS];
  logic [CW-1:0]           dcnt_d [NS];

  icpp_pkg::cstate_e       cs, nxt, ptarget, dtarget;
  logic                    active, busy, hit, pbm, dbm;
  logic [15:0]             ptime, dtime;
  logic [CW-1:0]           pc, dc;
  logic [HISTORY_BITS-1:0] mask_ext, hist_sh;
  logic [31:0]             tick_delta;

  // History shift and bus-master hit
  always_comb begin
    hist_sh  = {hist_q[HISTORY_BITS-2:0], bm_i};
    mask_ext = '0;
    mask_ext[MASK_W-1:0] = cfg_i.bus_master_mask[MASK_W-1:0];
    hit      = |(hist_sh & mask_ext);
  end

  // Busy demotion and per-state thresholds
  always_comb begin
    active     = (state_q != icpp_pkg::CST_C0);
    tick_delta = tick_i - last_q;
    busy       = (state_q != icpp_pkg::CST_C1) && (tick_delta >= cfg_i.busy_limit);
    cs         = busy ? icpp_pkg::CST_C1 : state_q;
    ptarget    = icpp_pkg::CST_C0;
    dtarget    = icpp_pkg::CST_C0;
    ptime      = '0;
    dtime      = '0;
    pbm        = 1'b0;
    dbm        = 1'b0;
    case (cs)
      icpp_pkg::CST_C1: begin
        if (cfg_i.deepest_state >= icpp_pkg::CST_C2) ptarget = icpp_pkg::CST_C2;
        ptime = cfg_i.promote_time_c1;
      end
      icpp_pkg::CST_C2: begin
        if (cfg_i.deepest_state == icpp_pkg::CST_C3) ptarget = icpp_pkg::CST_C3;
        ptime   = cfg_i.promote_time_c2;
        pbm     = 1'b1;
        dtarget = icpp_pkg::CST_C1;
        dtime   = cfg_i.demote_time_c2;
      end
      icpp_pkg::CST_C3: begin
        dtarget = icpp_pkg::CST_C2;
        dtime   = cfg_i.demote_time_c3;
        dbm     = 1'b1;
      end
      default: ;
    endcase
  end

  // Counter update and next-state decision
  always_comb begin
    pc  = pcnt_q[cs];
    dc  = dcnt_q[cs];
    nxt = cs;
    if (ptarget != icpp_pkg::CST_C0 && sleep_i >= {16'd0, ptime}) begin
      pc = icpp_pkg::sat_inc(pc);
      dc = '0;
      if (pc >= cfg_i.count_limit && !(pbm && hit)) nxt = ptarget;
    end
    if (dtarget != icpp_pkg::CST_C0) begin
      if (sleep_i < {16'd0, dtime}) begin
        dc = icpp_pkg::sat_inc(dc);
        pc = '0;
        if (dc >= cfg_i.count_limit) nxt = dtarget;
      end
      if (dbm && hit) nxt = dtarget;
    end
  end

  // Next state of all policy registers
  always_comb begin
    state_d = state_q;
    hist_d  = hist_q;
    last_d  = last_q;
    pcnt_d  = pcnt_q;
    dcnt_d  = dcnt_q;
    if (fire_i && active) begin
      state_d = nxt;
      hist_d  = hist_sh;
      last_d  = tick_i;
      for (int i = 0; i < NS; i++) begin
        // leaving a state clears its counters
        if (busy && state_q == icpp_pkg::cstate_e'(i)) begin
          pcnt_d[i] = '0;
          dcnt_d[i] = '0;
        end
        if (cs == icpp_pkg::cstate_e'(i)) begin
          pcnt_d[i] = (nxt != cs) ? '0 : pc;
          dcnt_d[i] = (nxt != cs) ? '0 : dc;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= icpp_pkg::CST_C1;
      hist_q  <= '0;
      last_q  <= '0;
      for (int i = 0; i < NS; i++) begin
        pcnt_q[i] <= '0;
        dcnt_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      hist_q  <= hist_d;
      last_q  <= last_d;
      pcnt_q  <= pcnt_d;
      dcnt_q  <= dcnt_d;
    end
  end

  // Result of this visit; a visit in C0 reports all zero
  always_comb begin
    res_o.sleep_state       = active ? cs : icpp_pkg::CST_C0;
    res_o.next_cstate       = active ? nxt : icpp_pkg::CST_C0;
    res_o.bus_master_reload = active && (nxt == icpp_pkg::CST_C3);
  end

endmodule

// ===== hw/rtl/idle_cstate_promotion_policy.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idle_cstate_promotion_policy
// Idle-visit C-state promotion / demotion policy with valid/ready channels.
// ----------------------------------------------------------------------------
// One request per idle visit is taken every clock cycle, except while the input
// register is full and the waiting result is not taken. A request first lands
// in an input register; the decision logic then reads the policy state, updates
// it and writes the result register, and a request is held in the input register
// while an earlier result waits to be taken. The decision loop through the state
// and counter registers sets the rate of one request per cycle.
// Write the configuration only while no request is in flight.
// ----------------------------------------------------------------------------
module idle_cstate_promotion_policy #(
  parameter int unsigned HISTORY_BITS = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [31:0]                     tick_now_i,
  input  logic                            bus_master_seen_i,
  input  logic [31:0]                     sleep_time_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [1:0]                      sleep_state_o,
  output logic [1:0]                      next_cstate_o,
  output logic                            bus_master_reload_o,
  input  logic                            cfg_we_i,
  input  logic [icpp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [icpp_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  icpp_pkg::cfg_t cfg;
  icpp_pkg::res_t res, res_q;
  logic           in_vld_q, out_vld_q, advance, fire;
  logic [31:0]    tick_q, sleep_q;
  logic           bm_q;

  icpp_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  icpp_step #(
    .HISTORY_BITS (HISTORY_BITS)
  ) u_step (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .fire_i  (fire),
    .tick_i  (tick_q),
    .bm_i    (bm_q),
    .sleep_i (sleep_q),
    .res_o   (res)
  );

  // Handshake: result slot frees on take, input slot frees on advance
  assign advance    = !out_vld_q || out_ready_i;
  assign fire       = in_vld_q && advance;
  assign in_ready_o = !in_vld_q || advance;

  // Valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_ready_o) in_vld_q <= in_valid_i;
      if (advance)    out_vld_q <= in_vld_q;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      tick_q  <= tick_now_i;
      bm_q    <= bus_master_seen_i;
      sleep_q <= sleep_time_i;
    end
    if (fire) res_q <= res;
  end

  assign out_valid_o         = out_vld_q;
  assign sleep_state_o       = res_q.sleep_state;
  assign next_cstate_o       = res_q.next_cstate;
  assign bus_master_reload_o = res_q.bus_master_reload;

`include "idle_cstate_promotion_policy_assert.svh"

  // C3 reload flag tracks the next state
  `ICPP_ASSERT_IMP(a_reload_c3, out_vld_q, bus_master_reload_o == (next_cstate_o == icpp_pkg::CST_C3))
  // C1 only ever promotes one step
  `ICPP_ASSERT_IMP(a_c1_no_jump, out_vld_q && sleep_state_o == icpp_pkg::CST_C1, next_cstate_o != icpp_pkg::CST_C3)
  // C3 only ever drops one step
  `ICPP_ASSERT_IMP(a_c3_one_step, out_vld_q && sleep_state_o == icpp_pkg::CST_C3, next_cstate_o != icpp_pkg::CST_C1)
  // A held request is not lost while the result is stalled
  `ICPP_ASSERT_NXT(a_hold_input, in_vld_q && !advance, in_vld_q)

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the idle C-state promotion policy. Idle-visit
// requests are driven with random bursts and gaps, results are drained by a
// receiver that stalls on its own pattern, and every result is compared with
// a cycle-free prediction of the policy state, history and counters.
// ----------------------------------------------------------------------------
module tb;

  localparam int HIST_W       = 32;
  localparam int QUIET_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 80;
  localparam int PHASES       = 8;
  localparam int PHASE_VISITS = 25;
  localparam int HOLD_VISITS  = 15;

  // Expected decisions of the policy, advanced once per accepted request
  class cstate_decision_board;
    localparam logic [63:0] HIST_KEEP = (64'h1 << HIST_W) - 64'h1;

    icpp_pkg::cfg_t    regs;
    icpp_pkg::cstate_e active;
    logic [63:0]       history;
    logic [31:0]       last_tick;
    logic [7:0]        promo_cnt [4];
    logic [7:0]        demo_cnt [4];
    icpp_pkg::res_t    pending_decisions [$];
    int                mismatches;

    function new();
      regs.busy_limit      = 32'd2;
      regs.deepest_state   = 2'd2;
      regs.promote_time_c1 = 16'd0;
      regs.promote_time_c2 = 16'd0;
      regs.demote_time_c2  = 16'd0;
      regs.demote_time_c3  = 16'd0;
      regs.count_limit     = 8'd1;
      regs.bus_master_mask = 32'h0000_000F;
      active     = icpp_pkg::CST_C1;
      history    = '0;
      last_tick  = '0;
      mismatches = 0;
      for (int i = 0; i < 4; i++) begin
        promo_cnt[i] = '0;
        demo_cnt[i]  = '0;
      end
    endfunction

    function void apply_reg(icpp_pkg::cfg_idx_e idx, logic [31:0] v);
      case (idx)
        icpp_pkg::CFG_BUSY_LIMIT:      regs.busy_limit      = v;
        icpp_pkg::CFG_DEEPEST_STATE:   regs.deepest_state   = v[1:0];
        icpp_pkg::CFG_PROMOTE_TIME_C1: regs.promote_time_c1 = v[15:0];
        icpp_pkg::CFG_PROMOTE_TIME_C2: regs.promote_time_c2 = v[15:0];
        icpp_pkg::CFG_DEMOTE_TIME_C2:  regs.demote_time_c2  = v[15:0];
        icpp_pkg::CFG_DEMOTE_TIME_C3:  regs.demote_time_c3  = v[15:0];
        icpp_pkg::CFG_COUNT_LIMIT:     regs.count_limit     = v[7:0];
        icpp_pkg::CFG_BUS_MASTER_MASK: regs.bus_master_mask = v;
        default: ;
      endcase
    endfunction

    function logic [7:0] sat_up(logic [7:0] c);
      return (c == 8'hFF) ? c : c + 8'd1;
    endfunction

    // Leaving a state wipes its counters
    function void enter_state(icpp_pkg::cstate_e nxt);
      promo_cnt[active] = '0;
      demo_cnt[active]  = '0;
      active            = nxt;
    endfunction

    function void note_visit(logic [31:0] tick, logic bm, logic [31:0] slept);
      icpp_pkg::res_t    r;
      icpp_pkg::cstate_e cs, nxt, up_to, down_to;
      logic [31:0]       up_time, down_time, since;
      bit                up_blockable, down_forced, bm_hit;
      up_to        = icpp_pkg::CST_C0;
      down_to      = icpp_pkg::CST_C0;
      up_time      = '0;
      down_time    = '0;
      up_blockable = 1'b0;
      down_forced  = 1'b0;
      // C0 never sleeps and leaves everything alone
      if (active == icpp_pkg::CST_C0) begin
        r.sleep_state       = icpp_pkg::CST_C0;
        r.next_cstate       = icpp_pkg::CST_C0;
        r.bus_master_reload = 1'b0;
        pending_decisions.push_back(r);
        return;
      end
      history = ((history << 1) | {63'h0, bm}) & HIST_KEEP;
      // busy OS falls back to C1 (C1 itself skips the check)
      since = tick - last_tick;
      if (active != icpp_pkg::CST_C1 && since >= regs.busy_limit)
        enter_state(icpp_pkg::CST_C1);
      cs  = active;
      nxt = cs;
      case (cs)
        icpp_pkg::CST_C1: begin
          if (regs.deepest_state >= icpp_pkg::CST_C2) up_to = icpp_pkg::CST_C2;
          up_time = {16'h0, regs.promote_time_c1};
        end
        icpp_pkg::CST_C2: begin
          if (regs.deepest_state == icpp_pkg::CST_C3) up_to = icpp_pkg::CST_C3;
          up_time      = {16'h0, regs.promote_time_c2};
          up_blockable = 1'b1;
          down_to      = icpp_pkg::CST_C1;
          down_time    = {16'h0, regs.demote_time_c2};
        end
        default: begin
          down_to     = icpp_pkg::CST_C2;
          down_time   = {16'h0, regs.demote_time_c3};
          down_forced = 1'b1;
        end
      endcase
      bm_hit = |(history & {32'h0, regs.bus_master_mask});
      // long sleep counts toward promotion
      if (up_to != icpp_pkg::CST_C0 && slept >= up_time) begin
        promo_cnt[cs] = sat_up(promo_cnt[cs]);
        demo_cnt[cs]  = '0;
        if (promo_cnt[cs] >= regs.count_limit && !(up_blockable && bm_hit)) nxt = up_to;
      end
      // short sleep counts toward demotion; bus-master activity forces it from C3
      if (down_to != icpp_pkg::CST_C0) begin
        if (slept < down_time) begin
          demo_cnt[cs]  = sat_up(demo_cnt[cs]);
          promo_cnt[cs] = '0;
          if (demo_cnt[cs] >= regs.count_limit) nxt = down_to;
        end
        if (down_forced && bm_hit) nxt = down_to;
      end
      if (nxt != active) enter_state(nxt);
      last_tick = tick;
      r.sleep_state       = cs;
      r.next_cstate       = active;
      r.bus_master_reload = (active == icpp_pkg::CST_C3);
      pending_decisions.push_back(r);
    endfunction

    function void check_decision(logic [1:0] sleep_st, logic [1:0] next_st, logic reload);
      icpp_pkg::res_t e;
      if (pending_decisions.size() == 0) begin
        $error("result with no request outstanding: sleep_state %0d next_cstate %0d",
               sleep_st, next_st);
        mismatches++;
        return;
      end
      e = pending_decisions.pop_front();
      if (sleep_st !== e.sleep_state) begin
        $error("sleep_state: expected %0d, got %0d", e.sleep_state, sleep_st);
        mismatches++;
      end
      if (next_st !== e.next_cstate) begin
        $error("next_cstate: expected %0d, got %0d", e.next_cstate, next_st);
        mismatches++;
      end
      if (reload !== e.bus_master_reload) begin
        $error("bus_master_reload: expected %0d, got %0d", e.bus_master_reload, reload);
        mismatches++;
      end
    endfunction
  endclass

  logic                            clk_i;
  logic                            rst_ni;
  logic                            in_valid_i;
  logic                            in_ready_o;
  logic [31:0]                     tick_now_i;
  logic                            bus_master_seen_i;
  logic [31:0]                     sleep_time_i;
  logic                            out_valid_o;
  logic                            out_ready_i;
  logic [1:0]                      sleep_state_o;
  logic [1:0]                      next_cstate_o;
  logic                            bus_master_reload_o;
  logic                            cfg_we_i;
  logic [icpp_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [icpp_pkg::CFG_DATA_W-1:0] cfg_data_i;

  cstate_decision_board decisions;
  logic [31:0]          staged_regs [8];
  logic [31:0]          tick_cur;
  int                   burst_left;
  int                   quiet_cycles = 0;
  int                   hold_reqs;
  bit                   steady;

  idle_cstate_promotion_policy #(
    .HISTORY_BITS(HIST_W)
  ) u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .tick_now_i         (tick_now_i),
    .bus_master_seen_i  (bus_master_seen_i),
    .sleep_time_i       (sleep_time_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .sleep_state_o      (sleep_state_o),
    .next_cstate_o      (next_cstate_o),
    .bus_master_reload_o(bus_master_reload_o),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Monitor both channels and watch for a hang
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o)
        decisions.note_visit(tick_now_i, bus_master_seen_i, sleep_time_i);
      if (out_valid_o && out_ready_i)
        decisions.check_decision(sleep_state_o, next_cstate_o, bus_master_reload_o);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("tb NOT OK");
          $finish;
        end
      end
    end
  end

  // Receiver: stall pattern redrawn at random from four modes, plus one long hold on demand
  initial begin
    int rx_cyc;
    int rx_mode;
    int holds_done;
    out_ready_i = 1'b0;
    rx_cyc      = 0;
    rx_mode     = 0;
    holds_done  = 0;
    forever begin
      @(negedge clk_i);
      if (hold_reqs != holds_done) begin
        holds_done++;
        out_ready_i = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
      rx_cyc++;
      if (rx_cyc % 32 == 0) rx_mode = $urandom_range(3);
      case (rx_mode)
        0:       out_ready_i = 1'b1;
        1:       out_ready_i = 1'($urandom_range(1));
        2:       out_ready_i = ($urandom_range(3) == 0);
        default: out_ready_i = (rx_cyc % 3 != 0);
      endcase
    end
  end

  // One request; the sender idles between bursts unless held steady
  task automatic offer_visit(input logic [31:0] t, input logic b, input logic [31:0] s);
    int idle;
    if (burst_left == 0 && !steady) begin
      idle = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
      if (idle > 0) begin
        in_valid_i = 1'b0;
        repeat (idle) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid_i        = 1'b1;
    tick_now_i        = t;
    bus_master_seen_i = b;
    sleep_time_i      = s;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    if (burst_left > 0) burst_left--;
  endtask

  task automatic wait_drained();
    in_valid_i = 1'b0;
    while (decisions.pending_decisions.size() != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic write_reg(input icpp_pkg::cfg_idx_e idx, input logic [31:0] v);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = v;
    decisions.apply_reg(idx, v);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // Consecutive ticks, fixed bus-master bit, any sleep time
  task automatic run_flat(input int n, input logic b);
    for (int i = 0; i < n; i++) begin
      tick_cur = tick_cur + 32'd1;
      offer_visit(tick_cur, b, $urandom);
    end
  endtask

  // Mostly well-formed visits: gaps under the busy limit, sleeps near thresholds
  task automatic roam(input int n, input int bm_pct);
    logic [31:0] lim, gap, thr, slept;
    for (int i = 0; i < n; i++) begin
      lim = decisions.regs.busy_limit;
      case ($urandom_range(11))
        0:       gap = '0;
        1:       gap = lim;
        2:       gap = lim - 32'd1;
        3:       gap = $urandom;
        default: gap = (lim >= 2) ? $urandom_range((lim > 40) ? 40 : lim - 1)
                                  : $urandom_range(3);
      endcase
      tick_cur = tick_cur + gap;
      if ($urandom_range(19) == 0) tick_cur = $urandom;
      case ($urandom_range(3))
        0:       thr = {16'h0, decisions.regs.promote_time_c1};
        1:       thr = {16'h0, decisions.regs.promote_time_c2};
        2:       thr = {16'h0, decisions.regs.demote_time_c2};
        default: thr = {16'h0, decisions.regs.demote_time_c3};
      endcase
      case ($urandom_range(7))
        0:       slept = '0;
        1:       slept = thr - 32'd1;
        2:       slept = thr;
        3:       slept = thr + 32'd1;
        4:       slept = $urandom;
        5:       slept = 32'hFFFF_FFFF;
        default: slept = $urandom_range(65535);
      endcase
      offer_visit(tick_cur, ($urandom_range(99) < bm_pct), slept);
    end
  endtask

  function automatic logic [15:0] pick_time();
    case ($urandom_range(3))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  initial begin
    decisions         = new();
    rst_ni            = 1'b0;
    in_valid_i        = 1'b0;
    tick_now_i        = '0;
    bus_master_seen_i = 1'b0;
    sleep_time_i      = '0;
    cfg_we_i          = 1'b0;
    cfg_idx_i         = icpp_pkg::CFG_BUSY_LIMIT;
    cfg_data_i        = '0;
    tick_cur          = '0;
    burst_left        = 0;
    hold_reqs         = 0;
    steady            = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Reset settings: C1 promotes on any sleep, busy from two ticks, tick wrap
    offer_visit(32'd1, 1'b0, 32'd0);
    offer_visit(32'd2, 1'b1, 32'hFFFF_FFFF);
    offer_visit(32'd4, 1'b0, 32'd0);
    offer_visit(32'hFFFF_FFFF, 1'b0, 32'd0);
    offer_visit(32'd0, 1'b1, 32'hFFFF_FFFF);
    wait_drained();

    // C2 to C3 with no mask, then C3 ignores bus-master activity
    write_reg(icpp_pkg::CFG_DEEPEST_STATE, 32'd3);
    write_reg(icpp_pkg::CFG_BUS_MASTER_MASK, 32'h0);
    write_reg(icpp_pkg::CFG_BUSY_LIMIT, 32'hFFFF_FFFF);
    offer_visit(32'd1, 1'b0, 32'd0);
    offer_visit(32'd2, 1'b1, 32'd0);
    wait_drained();

    // Full mask: C3 forced down, C2 promotion blocked
    write_reg(icpp_pkg::CFG_BUS_MASTER_MASK, 32'hFFFF_FFFF);
    offer_visit(32'd3, 1'b0, 32'd0);
    offer_visit(32'd4, 1'b0, 32'd0);
    wait_drained();

    // Zero count limit: the first qualifying sleep switches
    write_reg(icpp_pkg::CFG_DEMOTE_TIME_C2, 32'h0000_FFFF);
    write_reg(icpp_pkg::CFG_COUNT_LIMIT, 32'd0);
    offer_visit(32'd5, 1'b0, 32'h0000_FFFE);
    offer_visit(32'd6, 1'b0, 32'h0000_FFFF);
    wait_drained();

    // Deepest state of zero: no promotion, demotion still drains C2
    write_reg(icpp_pkg::CFG_DEEPEST_STATE, 32'd0);
    offer_visit(32'd7, 1'b0, 32'd0);
    offer_visit(32'd8, 1'b0, 32'h0000_FFFF);
    offer_visit(32'd9, 1'b0, 32'hFFFF_FFFF);
    wait_drained();

    // Saturation: C2 promotion held off by bus-master activity for over 255
    // visits, then released once the history clears
    tick_cur = 32'd9;
    write_reg(icpp_pkg::CFG_DEEPEST_STATE, 32'd3);
    write_reg(icpp_pkg::CFG_COUNT_LIMIT, 32'd1);
    write_reg(icpp_pkg::CFG_DEMOTE_TIME_C2, 32'd0);
    write_reg(icpp_pkg::CFG_PROMOTE_TIME_C1, 32'd0);
    write_reg(icpp_pkg::CFG_PROMOTE_TIME_C2, 32'd0);
    write_reg(icpp_pkg::CFG_DEMOTE_TIME_C3, 32'd0);
    run_flat(2, 1'b1);
    wait_drained();
    write_reg(icpp_pkg::CFG_COUNT_LIMIT, 32'd255);
    run_flat(270, 1'b1);
    run_flat(HIST_W + 2, 1'b0);

    // Random phases, every register rewritten between them
    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      case (p)
        0: begin
          staged_regs[icpp_pkg::CFG_BUSY_LIMIT]      = 32'd2;
          staged_regs[icpp_pkg::CFG_DEEPEST_STATE]   = 32'd2;
          staged_regs[icpp_pkg::CFG_PROMOTE_TIME_C1] = 32'd0;
          staged_regs[icpp_pkg::CFG_PROMOTE_TIME_C2] = 32'd0;
          staged_regs[icpp_pkg::CFG_DEMOTE_TIME_C2]  = 32'd0;
          staged_regs[icpp_pkg::CFG_DEMOTE_TIME_C3]  = 32'd0;
          staged_regs[icpp_pkg::CFG_COUNT_LIMIT]     = 32'd1;
          staged_regs[icpp_pkg::CFG_BUS_MASTER_MASK] = 32'h0000_000F;
        end
        1: begin
          staged_regs[icpp_pkg::CFG_BUSY_LIMIT]      = 32'd0;
          staged_regs[icpp_pkg::CFG_DEEPEST_STATE]   = 32'd3;
          staged_regs[icpp_pkg::CFG_PROMOTE_TIME_C1] = $urandom_range(65535);
          staged_regs[icpp_pkg::CFG_PROMOTE_TIME_C2] = $urandom_range(65535);
          staged_regs[icpp_pkg::CFG_DEMOTE_TIME_C2]  = $urandom_range(65535);
          staged_regs[icpp_pkg::CFG_DEMOTE_TIME_C3]  = $urandom_range(65535);
          staged_regs[icpp_pkg::CFG_COUNT_LIMIT]     = 32'd0;
          staged_regs[icpp_pkg::CFG_BUS_MASTER_MASK] = $urandom;
        end
        2: begin
          staged_regs[icpp_pkg::CFG_BUSY_LIMIT]      = 32'hFFFF_FFFF;
          staged_regs[icpp_pkg::CFG_DEEPEST_STATE]   = 32'd3;
          staged_regs[icpp_pkg::CFG_PROMOTE_TIME_C1] = 32'h0000_FFFF;
          staged_regs[icpp_pkg::CFG_PROMOTE_TIME_C2] = 32'h0000_FFFF;
          staged_regs[icpp_pkg::CFG_DEMOTE_TIME_C2]  = 32'h0000_FFFF;
          staged_regs[icpp_pkg::CFG_DEMOTE_TIME_C3]  = 32'h0000_FFFF;
          staged_regs[icpp_pkg::CFG_COUNT_LIMIT]     = 32'd255;
          staged_regs[icpp_pkg::CFG_BUS_MASTER_MASK] = 32'h0;
        end
        default: begin
          case ($urandom_range(4))
            0:       staged_regs[icpp_pkg::CFG_BUSY_LIMIT] = 32'd0;
            1:       staged_regs[icpp_pkg::CFG_BUSY_LIMIT] = 32'hFFFF_FFFF;
            2:       staged_regs[icpp_pkg::CFG_BUSY_LIMIT] = $urandom;
            default: staged_regs[icpp_pkg::CFG_BUSY_LIMIT] = $urandom_range(2, 60);
          endcase
          staged_regs[icpp_pkg::CFG_DEEPEST_STATE]   = $urandom_range(1, 3);
          staged_regs[icpp_pkg::CFG_PROMOTE_TIME_C1] = {16'h0, pick_time()};
          staged_regs[icpp_pkg::CFG_PROMOTE_TIME_C2] = {16'h0, pick_time()};
          staged_regs[icpp_pkg::CFG_DEMOTE_TIME_C2]  = {16'h0, pick_time()};
          staged_regs[icpp_pkg::CFG_DEMOTE_TIME_C3]  = {16'h0, pick_time()};
          staged_regs[icpp_pkg::CFG_COUNT_LIMIT]     = ($urandom_range(8) == 0)
                                                       ? 32'd255 : $urandom_range(1, 4);
          case ($urandom_range(3))
            0:       staged_regs[icpp_pkg::CFG_BUS_MASTER_MASK] = 32'h0;
            1:       staged_regs[icpp_pkg::CFG_BUS_MASTER_MASK] = 32'hFFFF_FFFF;
            2:       staged_regs[icpp_pkg::CFG_BUS_MASTER_MASK] = $urandom;
            default: staged_regs[icpp_pkg::CFG_BUS_MASTER_MASK] =
                       (32'h1 << $urandom_range(1, 6)) - 32'h1;
          endcase
        end
      endcase
      for (int i = 0; i < 8; i++) write_reg(icpp_pkg::cfg_idx_e'(i), staged_regs[i]);
      // Long receiver hold while requests keep coming, so the block backs up
      if (p == 4) begin
        hold_reqs++;
        steady = 1'b1;
        roam(HOLD_VISITS, 5);
        steady = 1'b0;
        roam(PHASE_VISITS - HOLD_VISITS, 5);
      end else begin
        roam(PHASE_VISITS, (p == 2) ? 30 : $urandom_range(0, 25));
      end
    end

    wait_drained();
    repeat (6) @(posedge clk_i);
    if (decisions.mismatches == 0 && decisions.pending_decisions.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/icpp_pkg.sv
hw/rtl/icpp_cfg_regs.sv
hw/rtl/icpp_step.sv
hw/rtl/idle_cstate_promotion_policy.sv
tb/tb.sv
